### rtl/bqd_pkg.sv
// Shared types, widths and register indexes for the biquad filter core.
// No dependencies; every other file in rtl/ refers to this package.
`default_nettype none

package bqd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int COEF_FRAC_DEF    = 28;

   localparam int COEF_W = 32;
   localparam int OP_W   = 32;             // second multiplier operand: x, y or clamped sum
   localparam int PROD_W = COEF_W + OP_W;
   localparam int OUT_W  = 24;
   localparam int SUM_W  = 32;             // sum is clamped to this before the gain multiply

   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FF0  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_FF1  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_FF2  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_FB1  = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_FB2  = CSR_IDX_W'(5);

   localparam logic [COEF_W-1:0] COEF_ONE_RESET = 32'h1000_0000;

   typedef logic [NUM_REGS-1:0][COEF_W-1:0] coef_bank_type;

   typedef struct packed {
      logic clear;    // zero the accumulator
      logic issue;    // load a new product
      logic accum;    // the product issued now is summed next cycle
      logic sub;      // ... and subtracted
   } mac_ctrl_type;

   // width of a product after the fractional bits are rounded off
   function automatic int rnd_width(input int frac);
      return PROD_W - frac;
   endfunction

   // five rounded products summed, with headroom
   function automatic int acc_width(input int frac);
      return PROD_W - frac + 3;
   endfunction

endpackage

`default_nettype wire

### rtl/bqd_stream_if.sv
// Valid/ready channel interfaces for sample requests and filtered responses.
// Depends on bqd_pkg for default widths.
`default_nettype none

interface bqd_req_if #(
   parameter int SAMPLE_WIDTH = bqd_pkg::SAMPLE_WIDTH_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqd_rsp_if ();
   logic                             valid;
   logic                             ready;
   logic signed [bqd_pkg::OUT_W-1:0] sample_out;
   logic                             clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

### rtl/bqd_csr.sv
// Coefficient and gain register bank, written through the plain csr port.
// Depends on bqd_pkg. Resets to a unity-gain bypass.
`default_nettype none

module bqd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              wr_en,
   input  wire logic [bqd_pkg::CSR_IDX_W-1:0]     wr_index,
   input  wire logic [bqd_pkg::COEF_W-1:0]        wr_data,
   output      bqd_pkg::coef_bank_type            bank
);

   bqd_pkg::coef_bank_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         // gain and b0 at 1.0, everything else zero
         for (int i = 0; i < bqd_pkg::NUM_REGS; i++) begin
            if ((bqd_pkg::CSR_IDX_W'(i) == bqd_pkg::REG_GAIN) ||
                (bqd_pkg::CSR_IDX_W'(i) == bqd_pkg::REG_FF0)) begin
               regs_ff[i] <= bqd_pkg::COEF_ONE_RESET;
            end else begin
               regs_ff[i] <= '0;
            end
         end
      end else if (wr_en) begin
         // indexes past the last register are dropped
         for (int i = 0; i < bqd_pkg::NUM_REGS; i++) begin
            if (wr_index == bqd_pkg::CSR_IDX_W'(i)) begin
               regs_ff[i] <= wr_data;
            end
         end
      end
   end

   assign bank = regs_ff;

endmodule

`default_nettype wire

### rtl/bqd_mac.sv
// Shared multiply-round-accumulate unit: one registered 32x32 product per cycle,
// rounded to nearest, summed into a wide accumulator. Depends on bqd_pkg.
`default_nettype none

module bqd_mac #(
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_DEF,
   parameter int RND_W          = bqd_pkg::rnd_width(COEF_FRAC_BITS),
   parameter int ACC_W          = bqd_pkg::acc_width(COEF_FRAC_BITS)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bqd_pkg::mac_ctrl_type             ctrl,
   input  wire logic signed [bqd_pkg::COEF_W-1:0] op_a,
   input  wire logic signed [bqd_pkg::OP_W-1:0]   op_b,
   output      logic signed [ACC_W-1:0]           acc,
   output      logic signed [RND_W-1:0]           rnd
);

   localparam int PROD_W = bqd_pkg::PROD_W;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] biased;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     pend_ff;
   logic                     sub_ff;

   // floor((p + half) / 2^F): ties go toward plus infinity
   assign biased = prod_ff + HALF;
   assign rnd    = biased[PROD_W-1:COEF_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sub_ff  <= 1'b0;
      end else begin
         pend_ff <= ctrl.issue & ctrl.accum;
         sub_ff  <= ctrl.sub;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (pend_ff) begin
         if (sub_ff) begin
            acc_ff <= acc_ff - ACC_W'(rnd);
         end else begin
            acc_ff <= acc_ff + ACC_W'(rnd);
         end
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### rtl/biquad_iir_filter_core.sv
// Biquad IIR section, direct form I, on one shared multiplier.
// A request is taken in idle and runs through five MAC steps, a drain, the gain
// multiply and a round/clamp step; with the single multiplier no new request is
// taken until it is idle again. The response register lets the next request in
// while a result waits; the core holds in its last step only if it is still full.
// Reset (synchronous, active high) clears history and loads bypass coefficients.
`default_nettype none

module biquad_iir_filter_core #(
   parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bqd_req_if.sink                            req_if,
   bqd_rsp_if.source                          rsp_if,
   input  wire logic                          csr_wr_en,
   input  wire logic [bqd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bqd_pkg::COEF_W-1:0]    csr_wdata
);

   localparam int RND_W  = bqd_pkg::rnd_width(COEF_FRAC_BITS);
   localparam int ACC_W  = bqd_pkg::acc_width(COEF_FRAC_BITS);
   localparam int OUT_W  = bqd_pkg::OUT_W;
   localparam int SUM_W  = bqd_pkg::SUM_W;
   localparam int OP_W   = bqd_pkg::OP_W;
   localparam int COEF_W = bqd_pkg::COEF_W;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [2:0] STEP_FF0 = 3'd0;
   localparam logic [2:0] STEP_FF1 = 3'd1;
   localparam logic [2:0] STEP_FF2 = 3'd2;
   localparam logic [2:0] STEP_FB1 = 3'd3;
   localparam logic [2:0] STEP_FB2 = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_GAIN,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic [2:0] step_ff;

   logic signed [SAMPLE_WIDTH-1:0] x0_ff, x1_ff, x2_ff;
   logic signed [OUT_W-1:0]        y1_ff, y2_ff;
   logic                           clip_ff;

   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_sample_ff;
   logic                    rsp_clip_ff;

   bqd_pkg::coef_bank_type     bank;
   bqd_pkg::mac_ctrl_type      mac_ctrl;
   logic signed [COEF_W-1:0]   op_a;
   logic signed [OP_W-1:0]     op_b;
   logic signed [ACC_W-1:0]    acc;
   logic signed [RND_W-1:0]    rnd;

   logic                    accept;
   logic                    sum_fits;
   logic signed [SUM_W-1:0] sum_sat;
   logic                    y_fits;
   logic signed [OUT_W-1:0] y_sat;
   logic                    out_free;

   bqd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .bank     (bank)
   );

   bqd_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .RND_W          (RND_W),
      .ACC_W          (ACC_W)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc),
      .rnd   (rnd)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid & req_if.ready;
   assign out_free     = ~rsp_valid_ff | rsp_if.ready;

   // clamp the sum to 32 bits before the gain multiply
   assign sum_fits = (&acc[ACC_W-1:SUM_W-1]) | ~(|acc[ACC_W-1:SUM_W-1]);
   assign sum_sat  = sum_fits ? acc[SUM_W-1:0] : (acc[ACC_W-1] ? SUM_MIN : SUM_MAX);

   assign y_fits = (&rnd[RND_W-1:OUT_W-1]) | ~(|rnd[RND_W-1:OUT_W-1]);
   assign y_sat  = y_fits ? rnd[OUT_W-1:0] : (rnd[RND_W-1] ? OUT_MIN : OUT_MAX);

   always_comb begin
      op_a = $signed(bank[bqd_pkg::REG_FF0]);
      op_b = OP_W'(x0_ff);
      if (state_ff == ST_GAIN) begin
         op_a = $signed(bank[bqd_pkg::REG_GAIN]);
         op_b = OP_W'(sum_sat);
      end else begin
         case (step_ff)
            STEP_FF0: begin
               op_a = $signed(bank[bqd_pkg::REG_FF0]);
               op_b = OP_W'(x0_ff);
            end
            STEP_FF1: begin
               op_a = $signed(bank[bqd_pkg::REG_FF1]);
               op_b = OP_W'(x1_ff);
            end
            STEP_FF2: begin
               op_a = $signed(bank[bqd_pkg::REG_FF2]);
               op_b = OP_W'(x2_ff);
            end
            STEP_FB1: begin
               op_a = $signed(bank[bqd_pkg::REG_FB1]);
               op_b = OP_W'(y1_ff);
            end
            STEP_FB2: begin
               op_a = $signed(bank[bqd_pkg::REG_FB2]);
               op_b = OP_W'(y2_ff);
            end
            default: begin
               op_a = $signed(bank[bqd_pkg::REG_FF0]);
               op_b = OP_W'(x0_ff);
            end
         endcase
      end
   end

   always_comb begin
      mac_ctrl.clear = accept;
      mac_ctrl.issue = (state_ff == ST_MUL) | (state_ff == ST_GAIN);
      mac_ctrl.accum = (state_ff == ST_MUL);
      mac_ctrl.sub   = (step_ff == STEP_FB1) | (step_ff == STEP_FB2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_FF0;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         if ((state_ff == ST_FIN) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  x0_ff    <= SAMPLE_WIDTH'(req_if.sample_in);
                  step_ff  <= STEP_FF0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == STEP_FB2) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               clip_ff  <= ~sum_fits;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_sample_ff <= y_sat;
                  rsp_clip_ff   <= clip_ff | ~y_fits;
                  x2_ff         <= x1_ff;
                  x1_ff         <= x0_ff;
                  y2_ff         <= y1_ff;
                  y1_ff         <= y_sat;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_sample_ff;
   assign rsp_if.clipped    = rsp_clip_ff;

endmodule

`default_nettype wire

### rtl/bqd_checker.sv
// Port-level checks for biquad_iir_filter_core, attached by the bind below.
// Depends only on the top level's ports and bqd_pkg widths.
`default_nettype none

module bqd_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [bqd_pkg::OUT_W-1:0] sample_out,
   input wire logic                      clipped
);

   // out of reset the core is empty and waiting for a request
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready && !rsp_valid)
      else $error("core not idle after reset");

   // a request keeps the core busy through its multiply sequence
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready
                                 ##1 !req_ready ##1 !req_ready)
      else $error("request accepted during multiply sequence");

   // a new response appears only at the end of a sequence, never from idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while core was idle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out) && $stable(clipped))
      else $error("stalled response changed");

endmodule

bind biquad_iir_filter_core bqd_checker u_bqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .sample_out (rsp_if.sample_out),
   .clipped    (rsp_if.clipped)
);

`default_nettype wire
